// ===== rtl/orq_pkg.sv =====
// Shared types and codes for the overwriting ring queue.
// No dependencies; imported by the top level.
package orq_pkg;

    // Fixed field widths
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int LEN_W   = 5;

    // Operation codes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Input item
    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] put_data;
    } t_orq_in;

    // Result item
    typedef struct packed {
        logic               [DATA_W-1:0] get_data;
        logic                            status;
        logic               [COUNT_W-1:0] element_count;
    } t_orq_out;

endpackage

// ===== rtl/orq_store.sv =====
// Element store for the ring queue: one write port, one registered read port.
// No package dependencies.
module orq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one element
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one element, hold the last read otherwise
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/overwriting_ring_queue.sv =====
// Overwriting ring queue: top level with handshakes, pointers and count.
// Depends on orq_pkg and orq_store.
//
// A circular FIFO whose run-time length comes from the length register
// (0 acts as 1, values above CAPACITY act as CAPACITY). Each item is a put
// or a get; a put on a full queue drops the oldest element. The block takes
// one item per cycle while the result channel does not stall; each item
// passes through the input register, then the pointer/count update and
// the store access into the result register. The store has one write
// port and one registered read port, so a put and the next get never
// contend. Writing the length register empties the queue at once; no
// clearing pass is needed since an entry is read only after it was written.
module overwriting_ring_queue #(
    parameter int CAPACITY   = 16,
    parameter int ELEM_BYTES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  orq_pkg::t_orq_in            i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output orq_pkg::t_orq_out           o_out,
    input  logic                        i_cfg_we,
    input  logic [orq_pkg::LEN_W-1:0]   i_cfg_data
);

    import orq_pkg::*;

    localparam int IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW      = ((IW > LEN_W) ? IW : LEN_W) + 1;
    localparam int EW      = (ELEM_BYTES * 8 > DATA_W) ? DATA_W : ELEM_BYTES * 8;
    localparam int LEN_RST = (CAPACITY < 16) ? CAPACITY : 16;

    // Control state
    logic               r_in_valid;
    t_orq_in            r_in;
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_status;
    logic [COUNT_W-1:0] r_out_count;
    logic [IW-1:0]      r_wr_idx, n_wr_idx;
    logic [IW-1:0]      r_rd_idx, n_rd_idx;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic [LEN_W-1:0]   r_len,    n_len;

    logic               advance;
    logic               proc;
    logic               in_accept;
    logic               is_put;
    logic               full;
    logic               empty;
    logic               st_wr_en;
    logic               st_rd_en;
    logic [EW-1:0]      st_rd_data;

    // Step an index around the current length
    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx,
                                             input logic [LEN_W-1:0] len);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= CW'(len)) ? '0 : inc[IW-1:0];
    endfunction

    // Handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_put = (r_in.operation == OP_PUT);
    assign full   = (r_count == COUNT_W'(r_len));
    assign empty  = (r_count == '0);

    assign st_wr_en = proc && is_put;
    assign st_rd_en = proc && !is_put && !empty;

    // Clamp a written length into 1..CAPACITY
    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(i_cfg_data) > CAPACITY) begin
            n_len = LEN_W'(CAPACITY);
        end else begin
            n_len = i_cfg_data;
        end
    end

    // Advance pointers and count for the item in the input register
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (proc) begin
            if (is_put) begin
                n_wr_idx = f_next(r_wr_idx, r_len);
                if (full) begin
                    n_rd_idx = f_next(r_rd_idx, r_len);
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end else if (!empty) begin
                n_rd_idx = f_next(r_rd_idx, r_len);
                n_count  = r_count - COUNT_W'(1);
            end
        end
    end

    // Queue state; a length write empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(LEN_RST);
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else if (i_cfg_we) begin
            r_len    <= n_len;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_hit    <= st_rd_en;
            r_out_status <= (!is_put && empty) ? STATUS_EMPTY : STATUS_OK;
            r_out_count  <= n_count;
        end
    end

    orq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (r_in.put_data[EW-1:0]),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (st_rd_data)
    );

    // Drive the result item; data only on a successful get
    assign o_out_valid         = r_out_valid;
    assign o_out.get_data      = r_out_hit ? DATA_W'(st_rd_data) : '0;
    assign o_out.status        = r_out_status;
    assign o_out.element_count = r_out_count;

    // Checks
    a_count_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(r_len))
        else $error("element count exceeds queue length");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_idx == r_rd_idx))
        else $error("empty queue with unequal pointers");

    a_partial_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != COUNT_W'(r_len)) |-> (r_wr_idx != r_rd_idx))
        else $error("partly filled queue with equal pointers");

    a_full_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && is_put && full && !i_cfg_we) |=> (r_count == $past(r_count)))
        else $error("put on full queue changed the count");

    a_refused_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STATUS_EMPTY) |->
            (r_out_count == '0 && !r_out_hit))
        else $error("refused get with nonzero count or data");

endmodule

// ===== dv/orq_checker.sv =====
// Checker for the overwriting ring queue: watches both channels and length writes.
// Holds its own queue model and compares every result item in order.
// Depends on orq_pkg.
module orq_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  orq_pkg::t_orq_in          i_in,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  orq_pkg::t_orq_out         i_out,
    input  logic                      i_cfg_we,
    input  logic [orq_pkg::LEN_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_results_owed,
    output int                        o_results_seen
);

    import orq_pkg::*;

    localparam int CAPACITY = 16;

    // Queue model state
    logic [DATA_W-1:0] ring_model [CAPACITY];
    int                wr_slot;
    int                rd_slot;
    int                fill;
    logic [LEN_W-1:0]  len_setting;

    t_orq_out          owed_results [$];
    int                fails;
    int                seen;

    // Clamp the length register to the range the queue can hold
    function automatic int active_length(logic [LEN_W-1:0] setting);
        if (setting == '0) begin
            return 1;
        end
        if (setting > CAPACITY) begin
            return CAPACITY;
        end
        return int'(setting);
    endfunction

    function automatic int next_slot(int idx, int len);
        return (idx + 1 >= len) ? 0 : idx + 1;
    endfunction

    // Apply one item to the model and return the result it should produce
    function automatic t_orq_out predict_queue_op(t_orq_in item);
        t_orq_out res;
        int       len;
        len = active_length(len_setting);
        res = '0;
        res.status = STATUS_OK;
        if (item.operation == OP_PUT) begin
            ring_model[wr_slot] = item.put_data;
            // a put on a full queue drops the oldest element
            if (fill == len) begin
                rd_slot = next_slot(rd_slot, len);
            end
            wr_slot = next_slot(wr_slot, len);
            if (fill < len) begin
                fill++;
            end
        end else if (fill == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.get_data = ring_model[rd_slot];
            rd_slot = next_slot(rd_slot, len);
            fill--;
        end
        res.element_count = fill[COUNT_W-1:0];
        return res;
    endfunction

    // Compare one result item against the oldest prediction
    task automatic compare_result(t_orq_out got);
        t_orq_out want;
        if (owed_results.size() == 0) begin
            $display("%0t: unexpected result item get_data=%h status=%0d count=%0d",
                     $time, got.get_data, got.status, got.element_count);
            fails++;
            return;
        end
        want = owed_results.pop_front();
        if (got.get_data !== want.get_data) begin
            $display("%0t: get_data mismatch, expected %h actual %h",
                     $time, want.get_data, got.get_data);
            fails++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
            fails++;
        end
        if (got.element_count !== want.element_count) begin
            $display("%0t: element_count mismatch, expected %0d actual %0d",
                     $time, want.element_count, got.element_count);
            fails++;
        end
    endtask

    initial begin
        fails = 0;
        seen  = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            ring_model[i] = '0;
        end
    end

    // Track length writes, accepted items and result items at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_setting = 5'd16;
            wr_slot     = 0;
            rd_slot     = 0;
            fill        = 0;
            owed_results.delete();
        end else begin
            // a length write empties the queue
            if (i_cfg_we) begin
                len_setting = i_cfg_data;
                wr_slot     = 0;
                rd_slot     = 0;
                fill        = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(predict_queue_op(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                seen++;
                compare_result(i_out);
            end
        end
        o_fail_count   <= fails;
        o_results_owed <= owed_results.size();
        o_results_seen <= seen;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the overwriting ring queue: clock, reset, stimulus, verdict.
// Drives directed and random put/get items under several idling patterns.
// Depends on orq_pkg, overwriting_ring_queue and orq_checker.
module tb;
    import orq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 98;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_orq_in          i_in        = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_orq_out         o_out;
    logic             i_cfg_we    = 1'b0;
    logic [LEN_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int results_owed;
    int results_seen;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int length_writes  = 0;
    int quiet_cycles   = 0;

    overwriting_ring_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    orq_checker u_orq_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in           (i_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out          (o_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no item moved in %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 83;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 83;
            end
            default: begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(logic op, logic [DATA_W-1:0] data);
        t_orq_in item;
        item.operation = op;
        item.put_data  = data;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Wait until every result is back, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        length_writes++;
    endtask

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Random bursts that lean toward puts or gets so the queue swings full and empty
    task automatic run_random_phase(int count);
        int sent;
        int burst;
        int put_pct;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(2))
                0:       put_pct = 15;
                1:       put_pct = 50;
                default: put_pct = 85;
            endcase
            for (int i = 0; i < burst && sent < count; i++) begin
                send_item(($urandom_range(99) < put_pct) ? OP_PUT : OP_GET, random_data());
                sent++;
            end
        end
    endtask

    initial begin
        logic [LEN_W-1:0] phase_lengths [8];
        phase_lengths = '{5'd16, 5'd1, 5'd17, 5'd31, 5'd3, 5'd0, 5'd8, 5'd16};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty get, data extremes, wrap and overwrite at short lengths
        set_idling(3);
        send_item(OP_GET, '0);
        send_item(OP_PUT, '0);
        send_item(OP_PUT, '1);
        send_item(OP_PUT, 32'hA5A5_5A5A);
        repeat (3) send_item(OP_GET, '1);
        send_item(OP_GET, '0);

        // length zero behaves as one element
        write_length(5'd0);
        send_item(OP_PUT, 32'h0000_0001);
        send_item(OP_PUT, 32'h0000_0002);
        send_item(OP_GET, '0);
        send_item(OP_GET, '0);

        // leave one element behind so the next write must flush it
        write_length(5'd2);
        send_item(OP_PUT, 32'h1111_1111);
        send_item(OP_PUT, 32'h2222_2222);
        send_item(OP_PUT, 32'h3333_3333);
        send_item(OP_GET, '0);

        // length above capacity behaves as full capacity
        write_length(5'd31);
        send_item(OP_GET, '0);
        send_item(OP_PUT, 32'h8000_0000);
        send_item(OP_GET, '0);

        // Random phases over length settings and idling patterns
        for (int p = 0; p < 9; p++) begin
            if (p < 8) begin
                write_length(phase_lengths[p]);
            end else begin
                write_length(LEN_W'($urandom_range(0, 31)));
            end
            set_idling(p % 4);
            run_random_phase(PHASE_ITEMS);
        end

        drain_results();
        $display("Sent %0d put/get items and checked %0d results across %0d length writes.",
                 items_sent, results_seen, length_writes);
        $display("Idling covered free flow, sparse input, heavy output stall and both mixed.");
        if (fail_count == 0 && results_owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/orq_pkg.sv
rtl/orq_store.sv
rtl/overwriting_ring_queue.sv
dv/orq_checker.sv
dv/tb.sv
